>>> src/mrcu_pkg.sv
// ----------------------------------------------------------------------------
// mrcu_pkg
// Shared types, codes and helpers for the multicycle control unit.
// ----------------------------------------------------------------------------
package mrcu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REGW = 5;
  localparam int unsigned F3W  = 3;

  typedef enum logic [2:0] {
    PH_FETCH     = 3'd0,
    PH_DECODE    = 3'd1,
    PH_MEMADDR   = 3'd2,
    PH_MEMREAD   = 3'd3,
    PH_MEMWRITE  = 3'd4,
    PH_EXECUTE   = 3'd5,
    PH_REGWRBACK = 3'd6
  } phase_t;

  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_IMM   = 7'h13;
  localparam logic [6:0] OP_STORE = 7'h23;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [1:0] BSEL_REG  = 2'd0;
  localparam logic [1:0] BSEL_FOUR = 2'd1;
  localparam logic [1:0] BSEL_IMM  = 2'd2;

  localparam logic [XLEN-1:0] IMM_SIGN_FILL = 32'hFFFF_F000;

  // Full architectural state; the visible part doubles as the result.
  typedef struct packed {
    phase_t            phase;
    logic [XLEN-1:0]   instr;
    logic              addr_from_alu;
    logic              reg_write_en;
    logic              mem_write_en;
    logic              mem_to_reg_sel;
    logic              alu_a_sel;
    logic [1:0]        alu_b_sel;
    logic [REGW-1:0]   src1_index;
    logic [REGW-1:0]   src2_index;
    logic [REGW-1:0]   dest_index;
    logic [XLEN-1:0]   immediate;
    logic [F3W-1:0]    func_code;
    logic [XLEN-1:0]   load_value;
  } ctrl_state_t;

  function automatic logic [XLEN-1:0] imm_i(input logic [XLEN-1:0] w);
    logic [XLEN-1:0] v;
    v = {20'd0, w[31:20]};
    return w[31] ? (IMM_SIGN_FILL | v) : v;
  endfunction

  function automatic logic [XLEN-1:0] imm_s(input logic [XLEN-1:0] w);
    logic [XLEN-1:0] v;
    v = {20'd0, w[31:25], w[11:7]};
    return w[31] ? (IMM_SIGN_FILL | v) : v;
  endfunction

endpackage

>>> src/multicycle_rv_control_unit_top.sv
// ----------------------------------------------------------------------------
// multicycle_rv_control_unit_top
// Multicycle control unit for RV32 loads, stores and immediate-ALU ops.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the controlled datapath: it carries the
// instruction bus word, the memory data_ready flag and the memory read word.
// Every accepted beat advances the phase sequence (Fetch, Decode, MemAddr or
// Execute, MemRead or MemWrite, RegWrBack) by exactly one step and yields
// exactly one result beat: the control outputs as they stand after that
// tick. Fetch and MemRead hold until data_ready is seen; an unknown opcode
// sends the unit back to Fetch with no output changed. Throughput is one beat
// per clock: the next-state logic is a single short combinational pass
// between the state register and itself, and the state register also serves
// as the result register. A new beat is taken in the same cycle that the
// previous result is taken, so input and output only stall each other when
// the output side holds off out_ready. out_valid rises in the cycle after
// input acceptance.
// ----------------------------------------------------------------------------
module multicycle_rv_control_unit_top
  import mrcu_pkg::*;
(
  input  logic            clk,
  input  logic            rst,

  input  logic            in_valid,
  output logic            in_ready,
  input  logic [XLEN-1:0] instr_word,
  input  logic            data_ready,
  input  logic [XLEN-1:0] mem_read_data,

  output logic            out_valid,
  input  logic            out_ready,
  output logic            addr_from_alu,
  output logic            reg_write_en,
  output logic            mem_write_en,
  output logic            mem_to_reg_sel,
  output logic            alu_a_sel,
  output logic [1:0]      alu_b_sel,
  output logic [REGW-1:0] src1_index,
  output logic [REGW-1:0] src2_index,
  output logic [REGW-1:0] dest_index,
  output logic [XLEN-1:0] immediate,
  output logic [F3W-1:0]  func_code,
  output logic [XLEN-1:0] load_value
);

  ctrl_state_t st;
  ctrl_state_t st_next;
  logic        in_fire;

  // Take a beat whenever the result slot is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  mrcu_step u_step (
    .cur           (st),
    .instr_word    (instr_word),
    .data_ready    (data_ready),
    .mem_read_data (mem_read_data),
    .nxt           (st_next)
  );

  // State register; it only moves on an accepted beat, so a stalled result
  // is held steady for free.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;  // all zero is Fetch with every output cleared
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign addr_from_alu  = st.addr_from_alu;
  assign reg_write_en   = st.reg_write_en;
  assign mem_write_en   = st.mem_write_en;
  assign mem_to_reg_sel = st.mem_to_reg_sel;
  assign alu_a_sel      = st.alu_a_sel;
  assign alu_b_sel      = st.alu_b_sel;
  assign src1_index     = st.src1_index;
  assign src2_index     = st.src2_index;
  assign dest_index     = st.dest_index;
  assign immediate      = st.immediate;
  assign func_code      = st.func_code;
  assign load_value     = st.load_value;

endmodule

>>> src/mrcu_load_size.sv
// ----------------------------------------------------------------------------
// mrcu_load_size
// Sizes the memory read word by funct3: byte, halfword or word.
// ----------------------------------------------------------------------------
module mrcu_load_size
  import mrcu_pkg::*;
(
  input  logic [F3W-1:0]  func_code,
  input  logic [XLEN-1:0] rdata,
  output logic [XLEN-1:0] sized
);

  always_comb begin
    unique case (func_code)
      F3_LB:   sized = {{24{rdata[7]}}, rdata[7:0]};
      F3_LH:   sized = {{16{rdata[15]}}, rdata[15:0]};
      F3_LBU:  sized = {24'd0, rdata[7:0]};
      F3_LHU:  sized = {16'd0, rdata[15:0]};
      default: sized = rdata;  // word, and the undefined codes
    endcase
  end

endmodule

>>> src/mrcu_step.sv
// ----------------------------------------------------------------------------
// mrcu_step
// Next-state logic: one phase of the control sequence per beat.
// ----------------------------------------------------------------------------
module mrcu_step
  import mrcu_pkg::*;
(
  input  ctrl_state_t     cur,
  input  logic [XLEN-1:0] instr_word,
  input  logic            data_ready,
  input  logic [XLEN-1:0] mem_read_data,
  output ctrl_state_t     nxt
);

  logic [6:0]      opc_held;
  logic [6:0]      opc_in;
  logic [F3W-1:0]  f3_held;
  logic [XLEN-1:0] load_sized;

  assign opc_held = cur.instr[6:0];
  assign opc_in   = instr_word[6:0];
  assign f3_held  = cur.instr[14:12];

  mrcu_load_size u_load_size (
    .func_code (f3_held),
    .rdata     (mem_read_data),
    .sized     (load_sized)
  );

  always_comb begin
    nxt       = cur;
    nxt.phase = PH_FETCH;
    unique case (cur.phase)
      PH_FETCH: begin
        nxt.addr_from_alu = 1'b0;
        nxt.reg_write_en  = 1'b0;
        nxt.mem_write_en  = 1'b0;
        if (data_ready) begin
          nxt.alu_a_sel = 1'b0;
          nxt.alu_b_sel = BSEL_FOUR;
          nxt.phase     = PH_DECODE;
        end else begin
          nxt.phase     = PH_FETCH;
        end
      end
      PH_DECODE: begin
        nxt.instr = instr_word;
        if (opc_in == OP_LOAD || opc_in == OP_STORE || opc_in == OP_IMM) begin
          nxt.src1_index = instr_word[19:15];
          nxt.immediate  = (opc_in == OP_STORE) ? imm_s(instr_word) : imm_i(instr_word);
          nxt.func_code  = instr_word[14:12];
          nxt.phase      = (opc_in == OP_IMM) ? PH_EXECUTE : PH_MEMADDR;
        end
      end
      PH_MEMADDR: begin
        nxt.alu_a_sel = 1'b1;
        nxt.alu_b_sel = BSEL_IMM;
        nxt.phase     = (opc_held == OP_STORE) ? PH_MEMWRITE : PH_MEMREAD;
      end
      PH_EXECUTE: begin
        nxt.alu_a_sel = 1'b1;
        nxt.alu_b_sel = BSEL_IMM;
        nxt.phase     = PH_REGWRBACK;
      end
      PH_MEMREAD: begin
        nxt.addr_from_alu = 1'b1;
        if (data_ready) begin
          nxt.load_value = load_sized;
          nxt.phase      = PH_REGWRBACK;
        end else begin
          nxt.phase      = PH_MEMREAD;
        end
      end
      PH_MEMWRITE: begin
        nxt.addr_from_alu = 1'b1;
        nxt.src2_index    = cur.instr[24:20];
        nxt.mem_write_en  = 1'b1;
      end
      PH_REGWRBACK: begin
        nxt.dest_index     = cur.instr[11:7];
        nxt.reg_write_en   = 1'b1;
        nxt.mem_to_reg_sel = (opc_held == OP_LOAD);
        nxt.func_code      = f3_held;
      end
      default: begin
        // unused phase code: hold everything, back to Fetch
      end
    endcase
  end

endmodule

>>> src/mrcu_checker.sv
// ----------------------------------------------------------------------------
// mrcu_checker
// Port-level checks for the control unit, bound onto the top level.
// ----------------------------------------------------------------------------
module mrcu_checker
  import mrcu_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            addr_from_alu,
  input logic            reg_write_en,
  input logic            mem_write_en,
  input logic            mem_to_reg_sel,
  input logic [XLEN-1:0] immediate
);

  // Empty result slot must never block the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with no result pending");

  // Stalled result beat holds.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(immediate) && $stable(reg_write_en))
    else $error("stalled result changed");

  // Register write and memory write are never issued together.
  a_write_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reg_write_en && mem_write_en))
    else $error("register and memory write both enabled");

  // A store drives the ALU address onto the memory bus.
  a_store_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write_en |-> addr_from_alu)
    else $error("store without ALU address");

  // Load write-back follows a data read from the ALU address.
  a_load_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write_en && mem_to_reg_sel |-> addr_from_alu)
    else $error("load write-back without memory read");

endmodule

bind multicycle_rv_control_unit_top mrcu_checker u_mrcu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .addr_from_alu  (addr_from_alu),
  .reg_write_en   (reg_write_en),
  .mem_write_en   (mem_write_en),
  .mem_to_reg_sel (mem_to_reg_sel),
  .immediate      (immediate)
);

>>> sim/tb_multicycle_rv_control_unit_top.sv
// ----------------------------------------------------------------------------
// tb_multicycle_rv_control_unit_top
// Self-checking bench for the multicycle RV32 control unit.
// ----------------------------------------------------------------------------
// A short table of directed beats walks the phase sequence first: the Fetch
// and MemRead waits, an unknown opcode, signed and unsigned loads, a store
// with every field at its top value, and an immediate-ALU op. Random beats
// follow. Most carry a load, store or immediate-ALU opcode so that the unit
// gets past Decode; the rest are raw words. Each accepted input beat is run
// through a local model of the unit, and each output beat is compared field
// by field with the oldest prediction. Both sides idle at random. The output
// side also holds off for one long stretch so that the input stalls. The
// sender also pauses once until every prediction has been matched.
// ----------------------------------------------------------------------------
module tb_multicycle_rv_control_unit_top;
  import mrcu_pkg::*;

  localparam int unsigned RANDOM_BEATS   = 1800;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned NUM_ROWS       = 27;

  // Output beat, fields in port order.
  typedef struct packed {
    logic            addr_from_alu;
    logic            reg_write_en;
    logic            mem_write_en;
    logic            mem_to_reg_sel;
    logic            alu_a_sel;
    logic [1:0]      alu_b_sel;
    logic [REGW-1:0] src1_index;
    logic [REGW-1:0] src2_index;
    logic [REGW-1:0] dest_index;
    logic [XLEN-1:0] immediate;
    logic [F3W-1:0]  func_code;
    logic [XLEN-1:0] load_value;
  } ctrl_out_t;

  // One directed beat; typed rows carry their own expected output.
  typedef struct packed {
    logic [XLEN-1:0] word;
    logic            rdy;
    logic [XLEN-1:0] rdata;
    logic            typed;
    ctrl_out_t       exp;
  } stim_row_t;

  // Outputs straight after a Fetch with data_ready, from reset.
  localparam ctrl_out_t FETCHED = '{alu_b_sel: BSEL_FOUR, default: '0};

  // Directed walk through the phases. Comments give the phase each beat hits.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, '0},      // Fetch, wait
    '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, FETCHED}, // Fetch, go
    '{32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b1, FETCHED}, // Decode, unknown op
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, FETCHED}, // Fetch, go
    '{32'hFFFF_8F83, 1'b0, 32'h0000_0000, 1'b0, '0},      // Decode lb, all ones
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // MemAddr
    '{32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},      // MemRead, wait
    '{32'h0000_0000, 1'b1, 32'h0000_0080, 1'b0, '0},      // MemRead, negative byte
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // RegWrBack
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0},      // Fetch
    '{32'h8000_1003, 1'b0, 32'h0000_0000, 1'b0, '0},      // Decode lh
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // MemAddr
    '{32'h0000_0000, 1'b1, 32'hFFFF_7FFF, 1'b0, '0},      // MemRead, positive half
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // RegWrBack
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0},      // Fetch
    '{32'h0000_4003, 1'b0, 32'h0000_0000, 1'b0, '0},      // Decode lbu
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // MemAddr
    '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},      // MemRead, zero-extend
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // RegWrBack
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0},      // Fetch
    '{32'hFFFF_FFA3, 1'b0, 32'h0000_0000, 1'b0, '0},      // Decode store, all ones
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // MemAddr
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // MemWrite
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, '0},      // Fetch
    '{32'h7FF0_0013, 1'b0, 32'h0000_0000, 1'b0, '0},      // Decode addi, top imm
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},      // Execute
    '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0}       // RegWrBack
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [XLEN-1:0] instr_word = '0;
  logic            data_ready = 1'b0;
  logic [XLEN-1:0] mem_read_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ctrl_out_t       dut_out;

  // Travel alongside the input beat so the monitor knows which rows are typed.
  logic            beat_typed = 1'b0;
  ctrl_out_t       beat_exp = '0;

  // Predictor state.
  phase_t          pr_phase = PH_FETCH;
  logic [XLEN-1:0] pr_instr = '0;
  ctrl_out_t       pr_out = '0;

  ctrl_out_t       pending_ctrl[$];
  int unsigned     mismatch_count = 0;
  int unsigned     results_checked = 0;
  int unsigned     beats_taken = 0;
  int unsigned     n_loads = 0;
  int unsigned     n_stores = 0;
  int unsigned     n_imm_ops = 0;
  int unsigned     n_unknown = 0;
  int unsigned     n_mem_waits = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multicycle_rv_control_unit_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .instr_word     (instr_word),
    .data_ready     (data_ready),
    .mem_read_data  (mem_read_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .addr_from_alu  (dut_out.addr_from_alu),
    .reg_write_en   (dut_out.reg_write_en),
    .mem_write_en   (dut_out.mem_write_en),
    .mem_to_reg_sel (dut_out.mem_to_reg_sel),
    .alu_a_sel      (dut_out.alu_a_sel),
    .alu_b_sel      (dut_out.alu_b_sel),
    .src1_index     (dut_out.src1_index),
    .src2_index     (dut_out.src2_index),
    .dest_index     (dut_out.dest_index),
    .immediate      (dut_out.immediate),
    .func_code      (dut_out.func_code),
    .load_value     (dut_out.load_value)
  );

  // One tick of the control unit: updates the local state and returns the
  // held outputs as they stand after the tick.
  task automatic step_control(input logic [XLEN-1:0] w, input logic rdy,
                              input logic [XLEN-1:0] rd, output ctrl_out_t res);
    logic [6:0] opc;
    logic [2:0] f3;
    phase_t     nxt;
    opc = pr_instr[6:0];
    f3  = pr_instr[14:12];
    nxt = PH_FETCH;
    case (pr_phase)
      PH_FETCH: begin
        pr_out.addr_from_alu = 1'b0;
        pr_out.reg_write_en  = 1'b0;
        pr_out.mem_write_en  = 1'b0;
        if (rdy) begin
          pr_out.alu_a_sel = 1'b0;
          pr_out.alu_b_sel = BSEL_FOUR;
          nxt = PH_DECODE;
        end else begin
          nxt = PH_FETCH;
        end
      end
      PH_DECODE: begin
        pr_instr = w;
        opc = w[6:0];
        if (opc == OP_LOAD || opc == OP_STORE || opc == OP_IMM) begin
          pr_out.src1_index = w[19:15];
          // S format splits the immediate around rd; I format is contiguous
          if (opc == OP_STORE)
            pr_out.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
          else
            pr_out.immediate = {{20{w[31]}}, w[31:20]};
          pr_out.func_code = w[14:12];
          nxt = (opc == OP_IMM) ? PH_EXECUTE : PH_MEMADDR;
          if (opc == OP_LOAD) n_loads++;
          else if (opc == OP_STORE) n_stores++;
          else n_imm_ops++;
        end else begin
          n_unknown++;
        end
      end
      PH_MEMADDR, PH_EXECUTE: begin
        pr_out.alu_a_sel = 1'b1;
        pr_out.alu_b_sel = BSEL_IMM;
        if (pr_phase == PH_EXECUTE)
          nxt = PH_REGWRBACK;
        else
          nxt = (opc == OP_STORE) ? PH_MEMWRITE : PH_MEMREAD;
      end
      PH_MEMREAD: begin
        pr_out.addr_from_alu = 1'b1;
        if (rdy) begin
          case (f3)
            F3_LB:   pr_out.load_value = {{24{rd[7]}}, rd[7:0]};
            F3_LH:   pr_out.load_value = {{16{rd[15]}}, rd[15:0]};
            F3_LBU:  pr_out.load_value = {24'd0, rd[7:0]};
            F3_LHU:  pr_out.load_value = {16'd0, rd[15:0]};
            default: pr_out.load_value = rd;   // lw and the undefined codes
          endcase
          nxt = PH_REGWRBACK;
        end else begin
          n_mem_waits++;
          nxt = PH_MEMREAD;
        end
      end
      PH_MEMWRITE: begin
        pr_out.addr_from_alu = 1'b1;
        pr_out.src2_index    = pr_instr[24:20];
        pr_out.mem_write_en  = 1'b1;
      end
      PH_REGWRBACK: begin
        pr_out.dest_index     = pr_instr[11:7];
        pr_out.reg_write_en   = 1'b1;
        pr_out.mem_to_reg_sel = (opc == OP_LOAD);
        pr_out.func_code      = f3;
      end
      default: ;   // spare phase encoding: nothing changes, back to Fetch
    endcase
    pr_phase = nxt;
    res = pr_out;
  endtask

  function automatic void check_field(input string name, input logic [XLEN-1:0] want,
                                      input logic [XLEN-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one input beat and hold it until the unit takes it.
  task automatic offer_beat(input logic [XLEN-1:0] w, input logic r,
                            input logic [XLEN-1:0] d, input logic typed,
                            input ctrl_out_t exp, input bit allow_gap);
    if (allow_gap) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    instr_word    <= w;
    data_ready    <= r;
    mem_read_data <= d;
    beat_typed    <= typed;
    beat_exp      <= exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Monitor: predicts on every accepted input beat, checks every output beat,
  // and ends the run if nothing moves for too long.
  always @(posedge clk) begin : monitor
    ctrl_out_t   want;
    ctrl_out_t   pred;
    int unsigned idle_cycles;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_ctrl.size() == 0) begin
          $error("output beat with no prediction waiting");
          mismatch_count++;
        end else begin
          want = pending_ctrl.pop_front();
          check_field("addr_from_alu", XLEN'(want.addr_from_alu),
                      XLEN'(dut_out.addr_from_alu));
          check_field("reg_write_en", XLEN'(want.reg_write_en),
                      XLEN'(dut_out.reg_write_en));
          check_field("mem_write_en", XLEN'(want.mem_write_en),
                      XLEN'(dut_out.mem_write_en));
          check_field("mem_to_reg_sel", XLEN'(want.mem_to_reg_sel),
                      XLEN'(dut_out.mem_to_reg_sel));
          check_field("alu_a_sel", XLEN'(want.alu_a_sel), XLEN'(dut_out.alu_a_sel));
          check_field("alu_b_sel", XLEN'(want.alu_b_sel), XLEN'(dut_out.alu_b_sel));
          check_field("src1_index", XLEN'(want.src1_index), XLEN'(dut_out.src1_index));
          check_field("src2_index", XLEN'(want.src2_index), XLEN'(dut_out.src2_index));
          check_field("dest_index", XLEN'(want.dest_index), XLEN'(dut_out.dest_index));
          check_field("immediate", want.immediate, dut_out.immediate);
          check_field("func_code", XLEN'(want.func_code), XLEN'(dut_out.func_code));
          check_field("load_value", want.load_value, dut_out.load_value);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        // the model always advances; typed rows just swap in their own answer
        step_control(instr_word, data_ready, mem_read_data, pred);
        pending_ctrl.push_back(beat_typed ? beat_exp : pred);
        beats_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Receiver: random back-pressure, one long hold-off so the input side
  // stalls, and a long stretch with out_ready tied high.
  initial begin : receiver
    int unsigned rcv_cycle;
    rcv_cycle = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rcv_cycle >= 800 && rcv_cycle < 1100)
        out_ready <= 1'b0;
      else if (rcv_cycle >= 1500 && rcv_cycle < 2200)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 26);
      @(posedge clk);
      rcv_cycle++;
    end
  end

  // Sender: reset, the directed table, then random beats.
  initial begin : sender
    logic [XLEN-1:0] w;
    int unsigned     sel;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer_beat(directed_rows[r].word, directed_rows[r].rdy, directed_rows[r].rdata,
                 directed_rows[r].typed, directed_rows[r].exp, 1'b1);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // one pause with nothing offered until the unit has caught up
      if (i == 1300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_ctrl.size() != 0) @(posedge clk);
      end
      // mostly real opcodes so Decode leads somewhere, the rest raw words
      w   = $urandom;
      sel = $urandom_range(9);
      case (sel)
        0, 1, 2: w[6:0] = OP_LOAD;
        3, 4, 5: w[6:0] = OP_STORE;
        6, 7:    w[6:0] = OP_IMM;
        default: ;
      endcase
      offer_beat(w, ($urandom_range(99) < 80), $urandom, 1'b0, '0,
                 !(i >= 500 && i < 900));
    end
    in_valid <= 1'b0;

    while (pending_ctrl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_ctrl.size() != 0) begin
      $error("%0d predictions never matched", pending_ctrl.size());
      mismatch_count++;
    end

    $display("Ran %0d input beats, checked %0d output beats, %0d field mismatches.",
             beats_taken, results_checked, mismatch_count);
    $display("Decoded %0d loads, %0d stores, %0d imm-ALU ops, %0d unknown; %0d read waits.",
             n_loads, n_stores, n_imm_ops, n_unknown, n_mem_waits);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
